// File: design/uer_pkg.sv
// Package for the ultrasonic echo ranger: request/response payload structs,
// register indexes, reset values and sizing constants.
// No dependencies.
package uer_pkg;

   localparam int COUNT_WIDTH_DEF = 16;

   localparam int DIST_W      = 20;
   localparam int TRIG_LEN_W  = 10;
   localparam int TIMEOUT_W   = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 20;

   // distance per echo tick in thousandths of a cm (36000 cm/s round trip)
   localparam int MILLICM_PER_TICK = 18;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_TICKS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_TIMEOUT  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_TIMEOUT  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DISTANCE  = 8'd3;

   localparam logic [TRIG_LEN_W-1:0] TRIGGER_TICKS_RST = 10'd10;
   localparam logic [TIMEOUT_W-1:0]  RISE_TIMEOUT_RST  = 16'd20000;
   localparam logic [TIMEOUT_W-1:0]  HIGH_TIMEOUT_RST  = 16'd40000;
   localparam logic [DIST_W-1:0]     MAX_DISTANCE_RST  = 20'd400000;

   typedef struct packed {
      logic start_req;
      logic echo;
   } req_type;

   typedef struct packed {
      logic              trigger;
      logic              done_res;
      logic [DIST_W-1:0] distance;
      logic              timed_out;
      logic              busy_res;
   } rsp_type;

endpackage

// File: design/ultrasonic_echo_ranger_core.sv
// Top level of the ultrasonic echo ranger: trigger/echo phase control, tick
// counter, distance scaling and clamp, response register and CSR bank.
// Depends on uer_pkg.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+---------------------------
//   req_    | in        | req_valid/req_stall  | req_type  (start_req, echo)
//   rsp_    | out       | rsp_valid/rsp_stall  | rsp_type  (trigger .. busy)
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One request (one microsecond tick) per clock unless stalled; each request
// yields exactly one response in the next cycle, set by the single response register.
// The request side stalls only while a held response is itself stalled.
// Reset (synchronous, active high) returns to idle with a zero tick count
// and loads the CSR reset values. CSR writes are always ready.
module ultrasonic_echo_ranger_core
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_TRIG = 2'd1;
   localparam logic [1:0] PH_WAIT = 2'd2;
   localparam logic [1:0] PH_HIGH = 2'd3;

   // compare width covering both the counter and the 16-bit timeouts
   localparam int CMP_W  = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
   // product width of count * 18, and compare width against max_distance
   localparam int PROD_W = COUNT_WIDTH + 5;
   localparam int DCMP_W = (PROD_W > DIST_W) ? PROD_W : DIST_W;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   // CSR bank
   logic [TRIG_LEN_W-1:0] trigger_ticks_ff;
   logic [TIMEOUT_W-1:0]  rise_timeout_ff;
   logic [TIMEOUT_W-1:0]  high_timeout_ff;
   logic [DIST_W-1:0]     max_distance_ff;

   // measurement state
   logic [1:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] tick_count_ff, tick_count_in;

   // response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic req_fire;
   logic csr_fire;

   logic [TRIG_LEN_W-1:0]  tlen;
   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic [CMP_W-1:0]       cnt_inc_x;
   logic [CMP_W-1:0]       tlen_x;
   logic [CMP_W-1:0]       rise_x;
   logic [CMP_W-1:0]       high_x;
   logic [PROD_W-1:0]      prod;
   logic [DIST_W-1:0]      dist_clamped;

   // Accept a new tick whenever the response register is free or draining.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A zero trigger length acts as one tick.
   assign tlen = (trigger_ticks_ff == '0) ? {{(TRIG_LEN_W-1){1'b0}}, 1'b1}
                                          : trigger_ticks_ff;

   // Saturating increment of the tick counter.
   assign cnt_inc   = (tick_count_ff == CNT_MAX) ? CNT_MAX : tick_count_ff + CNT_ONE;
   assign cnt_inc_x = CMP_W'(cnt_inc);
   assign tlen_x    = CMP_W'(tlen);
   assign rise_x    = CMP_W'(rise_timeout_ff);
   assign high_x    = CMP_W'(high_timeout_ff);

   // Echo width times 18 as shift-add, then clamp to max_distance.
   assign prod = (PROD_W'(tick_count_ff) << 4) + (PROD_W'(tick_count_ff) << 1);
   assign dist_clamped = (DCMP_W'(prod) > DCMP_W'(max_distance_ff))
                         ? max_distance_ff : DIST_W'(prod);

   always_comb begin
      phase_in         = phase_ff;
      tick_count_in    = tick_count_ff;
      rsp_in           = '0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_data.start_req) begin
               rsp_in.trigger  = 1'b1;
               rsp_in.busy_res = 1'b1;
               if (tlen == {{(TRIG_LEN_W-1){1'b0}}, 1'b1}) begin
                  phase_in      = PH_WAIT;
                  tick_count_in = '0;
               end else begin
                  phase_in      = PH_TRIG;
                  tick_count_in = CNT_ONE;
               end
            end
         end
         PH_TRIG: begin
            rsp_in.trigger  = 1'b1;
            rsp_in.busy_res = 1'b1;
            if (cnt_inc_x >= tlen_x || cnt_inc == CNT_MAX) begin
               phase_in      = PH_WAIT;
               tick_count_in = '0;
            end else begin
               tick_count_in = cnt_inc;
            end
         end
         PH_WAIT: begin
            if (req_data.echo) begin
               rsp_in.busy_res = 1'b1;
               phase_in        = PH_HIGH;
               tick_count_in   = CNT_ONE;
            end else if (cnt_inc_x > rise_x || cnt_inc == CNT_MAX) begin
               // echo never rose: report the ceiling with the timeout flag
               rsp_in.done_res  = 1'b1;
               rsp_in.timed_out = 1'b1;
               rsp_in.distance  = max_distance_ff;
               phase_in         = PH_IDLE;
               tick_count_in    = '0;
            end else begin
               rsp_in.busy_res = 1'b1;
               tick_count_in   = cnt_inc;
            end
         end
         PH_HIGH: begin
            if (!req_data.echo) begin
               // echo fell: width is the current count
               rsp_in.done_res = 1'b1;
               rsp_in.distance = dist_clamped;
               phase_in        = PH_IDLE;
               tick_count_in   = '0;
            end else if (cnt_inc_x > high_x || cnt_inc == CNT_MAX) begin
               rsp_in.done_res  = 1'b1;
               rsp_in.timed_out = 1'b1;
               rsp_in.distance  = max_distance_ff;
               phase_in         = PH_IDLE;
               tick_count_in    = '0;
            end else begin
               rsp_in.busy_res = 1'b1;
               tick_count_in   = cnt_inc;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Advance state and load the response only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff      <= phase_in;
            tick_count_ff <= tick_count_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // Response payload: hold while stalled, no reset needed.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // CSR writes; drop unknown indexes and surplus data bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff <= TRIGGER_TICKS_RST;
         rise_timeout_ff  <= RISE_TIMEOUT_RST;
         high_timeout_ff  <= HIGH_TIMEOUT_RST;
         max_distance_ff  <= MAX_DISTANCE_RST;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_TRIGGER_TICKS: trigger_ticks_ff <= csr_data[TRIG_LEN_W-1:0];
            CSR_RISE_TIMEOUT:  rise_timeout_ff  <= csr_data[TIMEOUT_W-1:0];
            CSR_HIGH_TIMEOUT:  high_timeout_ff  <= csr_data[TIMEOUT_W-1:0];
            CSR_MAX_DISTANCE:  max_distance_ff  <= csr_data[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // A finished measurement always leaves the block idle.
   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && rsp_in.done_res |=> phase_ff == PH_IDLE)
      else $error("phase not idle after done");

   // An accepted request always produces a response next cycle.
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request lost");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.done_res && rsp_ff.busy_res))
      else $error("done and busy together");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.done_res |-> rsp_ff.distance == '0 && !rsp_ff.timed_out)
      else $error("result fields set without done");

   a_trigger_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.trigger |-> rsp_ff.busy_res)
      else $error("trigger driven while not busy");

endmodule

// File: tb/ultrasonic_echo_ranger_core_tb.sv
// Self-checking testbench for ultrasonic_echo_ranger_core: a tick-accurate
// ranging predictor inside a small scoreboard class checks every response.
// Depends on uer_pkg and the ultrasonic_echo_ranger_core RTL.
module ultrasonic_echo_ranger_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import uer_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 12;
   localparam int MAX_REPORTS  = 10;
   localparam int CSR_NUM_REGS = 4;
   localparam int CSR_LAST_IDX = (1 << CSR_INDEX_W) - 1;
   localparam int CNT_W        = COUNT_WIDTH_DEF;
   localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
   localparam logic [DIST_W-1:0] DIST_FULL = '1;

   // Slowest correct stretch with no handshake at all: a sender gap,
   // a receiver stall run and the pauses before a CSR write or the verdict.
   // Take it many times over.
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum logic [1:0] {
      RANGE_IDLE,
      RANGE_TRIGGER,
      RANGE_WAIT_RISE,
      RANGE_ECHO_HIGH
   } range_phase_e;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC
   } stall_mode_e;

   // Predict the response of every accepted tick and compare against the
   // responses in order.
   class echo_ranger_scoreboard;
      logic [TRIG_LEN_W-1:0] trigger_len;
      logic [TIMEOUT_W-1:0]  rise_limit;
      logic [TIMEOUT_W-1:0]  high_limit;
      logic [DIST_W-1:0]     distance_cap;
      range_phase_e          phase;
      int unsigned           ticks;
      rsp_type               pending_readings[$];
      int                    errors;
      int                    reported;

      function new();
         trigger_len  = TRIGGER_TICKS_RST;
         rise_limit   = RISE_TIMEOUT_RST;
         high_limit   = HIGH_TIMEOUT_RST;
         distance_cap = MAX_DISTANCE_RST;
         phase        = RANGE_IDLE;
         ticks        = 0;
         errors       = 0;
         reported     = 0;
      endfunction

      // Unknown indexes are dropped, and so are data bits above the width.
      function void load_register(logic [CSR_INDEX_W-1:0] idx,
                                  logic [CSR_DATA_W-1:0] word);
         case (idx)
            CSR_TRIGGER_TICKS: trigger_len  = word[TRIG_LEN_W-1:0];
            CSR_RISE_TIMEOUT:  rise_limit   = word[TIMEOUT_W-1:0];
            CSR_HIGH_TIMEOUT:  high_limit   = word[TIMEOUT_W-1:0];
            CSR_MAX_DISTANCE:  distance_cap = word[DIST_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned bump(int unsigned c);
         return (c >= CNT_MAX) ? CNT_MAX : c + 1;
      endfunction

      function void note_tick(req_type r);
         rsp_type     e;
         int unsigned trig_len_eff;
         int unsigned span_mcm;
         bit          timeout_hit;
         e = '0;
         timeout_hit = 1'b0;
         trig_len_eff = (trigger_len == '0) ? 32'd1 : 32'(trigger_len);
         case (phase)
            RANGE_IDLE: begin
               if (r.start_req) begin
                  e.trigger  = 1'b1;
                  e.busy_res = 1'b1;
                  ticks = 1;
                  if (ticks >= trig_len_eff) begin
                     phase = RANGE_WAIT_RISE;
                     ticks = 0;
                  end else begin
                     phase = RANGE_TRIGGER;
                  end
               end
            end
            RANGE_TRIGGER: begin
               e.trigger  = 1'b1;
               e.busy_res = 1'b1;
               ticks = bump(ticks);
               if (ticks >= trig_len_eff || ticks >= CNT_MAX) begin
                  phase = RANGE_WAIT_RISE;
                  ticks = 0;
               end
            end
            RANGE_WAIT_RISE: begin
               if (r.echo) begin
                  e.busy_res = 1'b1;
                  phase = RANGE_ECHO_HIGH;
                  ticks = 1;
               end else begin
                  ticks = bump(ticks);
                  if (ticks > rise_limit || ticks >= CNT_MAX) timeout_hit = 1'b1;
                  else e.busy_res = 1'b1;
               end
            end
            default: begin
               if (r.echo) begin
                  ticks = bump(ticks);
                  if (ticks > high_limit || ticks >= CNT_MAX) timeout_hit = 1'b1;
                  else e.busy_res = 1'b1;
               end else begin
                  span_mcm = ticks * MILLICM_PER_TICK;
                  if (span_mcm > distance_cap) span_mcm = 32'(distance_cap);
                  e.done_res = 1'b1;
                  e.distance = span_mcm[DIST_W-1:0];
                  phase = RANGE_IDLE;
                  ticks = 0;
               end
            end
         endcase
         if (timeout_hit) begin
            e.done_res  = 1'b1;
            e.timed_out = 1'b1;
            e.distance  = distance_cap;
            phase = RANGE_IDLE;
            ticks = 0;
         end
         pending_readings.push_back(e);
      endfunction

      function void check_reading(rsp_type got);
         rsp_type want;
         if (pending_readings.size() == 0) begin
            errors++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("[%0t] response with no request pending", $time);
            end
            return;
         end
         want = pending_readings.pop_front();
         if (got.trigger !== want.trigger || got.done_res !== want.done_res ||
             got.distance !== want.distance || got.timed_out !== want.timed_out ||
             got.busy_res !== want.busy_res) begin
            errors++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("[%0t] reading mismatch: expected trig=%0b done=%0b dist=%0d tmo=%0b busy=%0b",
                        $time, want.trigger, want.done_res, want.distance,
                        want.timed_out, want.busy_res);
               $display("          got      trig=%0b done=%0b dist=%0d tmo=%0b busy=%0b",
                        got.trigger, got.done_res, got.distance,
                        got.timed_out, got.busy_res);
            end
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and block signals; every input known from time zero.
   // ------------------------------------------------------------------
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   echo_ranger_scoreboard sb;

   int          burst_left   = 0;
   bit          sender_gaps  = 1'b1;
   int          items_sent   = 0;
   int          quiet_cycles = 0;
   stall_mode_e stall_mode   = STALL_NONE;
   int          stall_left   = 0;
   int unsigned stall_tick   = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   ultrasonic_echo_ranger_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Receiver: switch between no stall, random stall and a periodic stall
   // pattern at random intervals so stalls land on every phase.
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_left == 0) begin
         stall_mode <= stall_mode_e'($urandom_range(0, 2));
         stall_left <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         default:      rsp_stall <= ((stall_tick % 11) < 4);
      endcase
   end

   // Check each accepted response; count cycles without any handshake.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_reading(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("[%0t] watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Send one tick request. Work in bursts; between bursts drop valid for a
   // random gap unless gaps are switched off. Hold the payload while stalled.
   task automatic send_tick(input logic start, input logic echo);
      req_type item;
      int      gap;
      item.start_req = start;
      item.echo      = echo;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.note_tick(item);
      items_sent++;
   endtask

   // Stop sending and wait until every predicted response has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_readings.size() != 0) @(posedge clock);
   endtask

   // Walk the block back to idle the shortest way (finish the trigger,
   // raise echo in the rise wait, drop it in the high phase), then drain.
   task automatic settle_and_drain();
      while (sb.phase != RANGE_IDLE) send_tick(1'b0, sb.phase == RANGE_WAIT_RISE);
      hold_until_drained();
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] word);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= word;
      do @(posedge clock); while (!csr_ready);
      sb.load_register(idx, word);
   endtask

   // Reprogram all registers with the block idle. Random upper data bits
   // must be dropped, and a write to an unknown index must be ignored.
   task automatic configure(input int unsigned trig, input int unsigned rise,
                            input int unsigned high, input int unsigned cap);
      logic [CSR_DATA_W-1:0] word;
      settle_and_drain();
      csr_write(CSR_INDEX_W'($urandom_range(CSR_NUM_REGS, CSR_LAST_IDX)),
                CSR_DATA_W'($urandom));
      word = CSR_DATA_W'($urandom);
      word[TRIG_LEN_W-1:0] = trig[TRIG_LEN_W-1:0];
      csr_write(CSR_TRIGGER_TICKS, word);
      word = CSR_DATA_W'($urandom);
      word[TIMEOUT_W-1:0] = rise[TIMEOUT_W-1:0];
      csr_write(CSR_RISE_TIMEOUT, word);
      word = CSR_DATA_W'($urandom);
      word[TIMEOUT_W-1:0] = high[TIMEOUT_W-1:0];
      csr_write(CSR_HIGH_TIMEOUT, word);
      csr_write(CSR_MAX_DISTANCE, cap[DIST_W-1:0]);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One measurement with random content: start, trigger and rise wait with
   // echo low, an echo pulse, then echo low. About one in four overruns the
   // rise or high window to force a timeout; stray starts while busy.
   task automatic random_measurement();
      int unsigned trig_eff;
      int unsigned low_ticks;
      int unsigned width;
      trig_eff = (sb.trigger_len == '0) ? 32'd1 : 32'(sb.trigger_len);
      low_ticks = ($urandom_range(0, 3) == 0) ?
                  $urandom_range(sb.rise_limit + 1, sb.rise_limit + 3) :
                  $urandom_range(0, sb.rise_limit);
      width = ($urandom_range(0, 3) == 0) ?
              $urandom_range(sb.high_limit + 1, sb.high_limit + 3) :
              $urandom_range(1, sb.high_limit);
      send_tick(1'b1, 1'($urandom_range(0, 1)));
      repeat (trig_eff - 1 + low_ticks) send_tick($urandom_range(0, 4) == 0, 1'b0);
      repeat (width) send_tick($urandom_range(0, 4) == 0, 1'b1);
      send_tick(1'b0, 1'b0);
      repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int          quota;
      int unsigned cap;
      bit          paused;
      sb = new();
      paused = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values: 10-tick trigger with starts while busy, then a
      // one-tick echo pulse from the settle walk.
      repeat (4) send_tick(1'b1, 1'b0);

      // All registers at zero: trigger of zero acts as one tick, zero rise
      // and high timeouts fire on the first tick, and a clamp to zero.
      configure(0, 0, 0, 0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);

      // Random part over several small settings, so timeouts and clamps
      // are frequent. One setting runs the sender without gaps.
      for (int cfg = 0; cfg < 5; cfg++) begin
         case ($urandom_range(0, 3))
            0:       cap = 0;
            1:       cap = DIST_FULL;
            default: cap = $urandom_range(18, 400);
         endcase
         configure($urandom_range(0, 8), $urandom_range(0, 16),
                   $urandom_range(0, 24), cap);
         sender_gaps = (cfg != 3);
         quota = items_sent + 270;
         while (items_sent < quota) begin
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 8))
                  send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
               random_measurement();
            // Once, partway through the quota, hold off until all responses are back.
            if (cfg == 2 && !paused && items_sent > quota - 150) begin
               hold_until_drained();
               paused = 1'b1;
            end
         end
      end

      // Upper range: a long trigger, the widest timeouts and distance range,
      // stray starts in the rise wait, then an echo pulse well inside the
      // high window.
      sender_gaps = 1'b0;
      configure(200, 65535, 65535, DIST_FULL);
      send_tick(1'b1, 1'b0);
      while (sb.phase != RANGE_WAIT_RISE) send_tick(1'b0, 1'b0);
      repeat (20) send_tick(1'b1, 1'b0);
      repeat (60) send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);

      hold_until_drained();
      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.pending_readings.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: filelist.f
design/uer_pkg.sv
design/ultrasonic_echo_ranger_core.sv
tb/ultrasonic_echo_ranger_core_tb.sv
